/* rtl/core/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define KCT_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define KCT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/kct_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kct_pkg - shared types for the keyed cost table
// Request codes, field widths and the token that walks the cell chain.
// ---------------------------------------------------------------------------
package kct_pkg;

    localparam int KEY_W   = 44;
    localparam int COST_W  = 24;
    localparam int TOTAL_W = 29;
    localparam int ECNT_W  = 6;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_DEL   = 2'd1,
        REQ_GET   = 2'd2,
        REQ_TOTAL = 2'd3
    } req_t;

    // Request state handed from one cell to the next
    typedef struct packed {
        logic               active;
        req_t               req;
        logic [KEY_W-1:0]   key;
        logic [COST_W-1:0]  cost;
        logic               names;
        logic               found;
        logic               added;
        logic [COST_W-1:0]  found_cost;
        logic [TOTAL_W-1:0] sum;
    } token_t;

    // One result word
    typedef struct packed {
        logic               ok;
        logic [COST_W-1:0]  found_cost;
        logic [TOTAL_W-1:0] total;
        logic [ECNT_W-1:0]  count;
    } result_t;

endpackage

/* rtl/core/kct_cell.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kct_cell - one table slot
// Holds one key and cost, acts on the passing request token and hands the
// token on to the next slot in the following cycle.
// ---------------------------------------------------------------------------
module kct_cell #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 6
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [CNT_W-1:0]           fill,
    input  kct_pkg::token_t            tok_in,
    output kct_pkg::token_t            tok_out,
    input  logic [kct_pkg::KEY_W-1:0]  nbr_key,
    input  logic [kct_pkg::COST_W-1:0] nbr_cost,
    output logic [kct_pkg::KEY_W-1:0]  key_out,
    output logic [kct_pkg::COST_W-1:0] cost_out
);
    import kct_pkg::*;

    logic [KEY_W-1:0]   key_reg,  key_next;
    logic [COST_W-1:0]  cost_reg, cost_next;
    token_t             tok_reg,  tok_next;
    logic               occupied;
    logic               is_tail;
    logic               hit;
    logic [TOTAL_W:0]   sum_wide;

    assign occupied = (CNT_W'(CELL_IDX) < fill);
    assign is_tail  = (CNT_W'(CELL_IDX) == fill);
    assign hit      = occupied && !tok_in.found && (key_reg == tok_in.key);
    assign sum_wide = {1'b0, tok_in.sum} + (TOTAL_W+1)'(cost_reg);

    // Slot update and token hand-on
    always_comb begin
        key_next  = key_reg;
        cost_next = cost_reg;
        tok_next  = tok_in;
        if (tok_in.active) begin
            tok_next.found = tok_in.found | hit;
            case (tok_in.req)
                REQ_ADD: begin
                    if (hit) begin
                        cost_next = tok_in.cost;
                    end else if (is_tail && !tok_in.found && tok_in.names) begin
                        key_next       = tok_in.key;
                        cost_next      = tok_in.cost;
                        tok_next.added = 1'b1;
                    end
                end
                REQ_DEL: begin
                    // from the match onwards every slot takes its right neighbour; the last slot keeps its own
                    if (hit || tok_in.found) begin
                        key_next  = nbr_key;
                        cost_next = nbr_cost;
                    end
                end
                REQ_GET: begin
                    if (hit) begin
                        tok_next.found_cost = cost_reg;
                    end
                end
                REQ_TOTAL: begin
                    if (occupied) begin
                        tok_next.sum = sum_wide[TOTAL_W] ? {TOTAL_W{1'b1}}
                                                         : sum_wide[TOTAL_W-1:0];
                    end
                end
                default: begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    // Slot contents need no reset
    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        cost_reg <= cost_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg        <= '0;
        end else begin
            tok_reg        <= tok_next;
        end
    end

    assign tok_out  = tok_reg;
    assign key_out  = key_reg;
    assign cost_out = cost_reg;

endmodule

/* rtl/core/keyed_cost_table.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// keyed_cost_table - packed key/cost table built as a row of slot cells
// Add or update, delete with shift-down, retrieve and saturating total.
// ---------------------------------------------------------------------------
// One request is handled at a time. On acceptance a token enters slot 0 and
// moves one slot per cycle along the row of TABLE_DEPTH cells, which search,
// update, append, shift down or add up as it passes. The result word is
// registered from the token that leaves the last cell, and the next request
// can be accepted only after that token has left the row. A single result
// waiting on m_ready does not hold off the next request: one more result is
// buffered behind the output register, and while that buffer is full no new
// request is accepted. The table is empty after reset, with no clearing pass.
module keyed_cost_table #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_req_type,
    input  logic [kct_pkg::KEY_W-1:0]   s_isbn,
    input  logic [kct_pkg::COST_W-1:0]  s_cost_cents,
    input  logic                        s_names_present,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_ok,
    output logic [kct_pkg::COST_W-1:0]  m_found_cost,
    output logic [kct_pkg::TOTAL_W-1:0] m_total_cents,
    output logic [kct_pkg::ECNT_W-1:0]  m_entry_count
);
    import kct_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    token_t             tok_w  [0:TABLE_DEPTH];
    logic [KEY_W-1:0]   key_w  [0:TABLE_DEPTH-1];
    logic [COST_W-1:0]  cost_w [0:TABLE_DEPTH-1];

    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               busy_reg, busy_next;
    result_t            out_reg, out_next;
    result_t            hold_reg, hold_next;
    logic               out_valid_reg, out_valid_next;
    logic               hold_valid_reg, hold_valid_next;
    logic               accept;
    logic               emerge;
    token_t             tok_head;
    token_t             tok_end;
    result_t            res;
    logic [CNT_W+ECNT_W-1:0] fill_ext;

    assign s_ready = !busy_reg && !hold_valid_reg;
    assign accept  = s_valid && s_ready;

    // Token injected into the first slot
    always_comb begin
        tok_head            = '0;
        tok_head.active     = accept;
        tok_head.req        = req_t'(s_req_type);
        tok_head.key        = s_isbn;
        tok_head.cost       = s_cost_cents;
        tok_head.names      = s_names_present;
    end

    assign tok_w[0] = tok_head;

    // Row of slot cells
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        if (i == TABLE_DEPTH - 1) begin : g_last
            kct_cell #(.CELL_IDX(i), .CNT_W(CNT_W)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .fill     (fill_reg),
                .tok_in   (tok_w[i]),
                .tok_out  (tok_w[i+1]),
                .nbr_key  (key_w[i]),
                .nbr_cost (cost_w[i]),
                .key_out  (key_w[i]),
                .cost_out (cost_w[i])
            );
        end else begin : g_mid
            kct_cell #(.CELL_IDX(i), .CNT_W(CNT_W)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .fill     (fill_reg),
                .tok_in   (tok_w[i]),
                .tok_out  (tok_w[i+1]),
                .nbr_key  (key_w[i+1]),
                .nbr_cost (cost_w[i+1]),
                .key_out  (key_w[i]),
                .cost_out (cost_w[i])
            );
        end
    end

    assign tok_end = tok_w[TABLE_DEPTH];
    assign emerge  = tok_end.active;

    // Fill count after the finished request
    always_comb begin
        fill_next = fill_reg;
        if (emerge) begin
            if (tok_end.req == REQ_ADD && tok_end.added) begin
                fill_next = fill_reg + CNT_W'(1);
            end else if (tok_end.req == REQ_DEL && tok_end.found) begin
                fill_next = fill_reg - CNT_W'(1);
            end
        end
    end

    assign fill_ext = {{ECNT_W{1'b0}}, fill_next};

    // Result word
    always_comb begin
        res            = '0;
        res.found_cost = tok_end.found_cost;
        res.total      = tok_end.sum;
        res.count      = fill_ext[ECNT_W-1:0];
        case (tok_end.req)
            REQ_ADD:   res.ok = tok_end.found | tok_end.added;
            REQ_DEL:   res.ok = tok_end.found;
            REQ_GET:   res.ok = tok_end.found;
            REQ_TOTAL: res.ok = 1'b1;
            default:   res.ok = 1'b0;
        endcase
    end

    // Output register with one buffered word behind it
    always_comb begin
        out_next        = out_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg;
        hold_valid_next = hold_valid_reg;
        busy_next       = busy_reg;
        if (out_valid_reg && m_ready) begin
            if (hold_valid_reg) begin
                out_next        = hold_reg;
                hold_valid_next = 1'b0;
            end else begin
                out_valid_next  = 1'b0;
            end
        end
        if (emerge) begin
            busy_next = 1'b0;
            if (!out_valid_next) begin
                out_next       = res;
                out_valid_next = 1'b1;
            end else begin
                hold_next       = res;
                hold_valid_next = 1'b1;
            end
        end
        if (accept) begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            fill_reg       <= fill_next;
            busy_reg       <= busy_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_ok          = out_reg.ok;
    assign m_found_cost  = out_reg.found_cost;
    assign m_total_cents = out_reg.total;
    assign m_entry_count = out_reg.count;

endmodule

/* rtl/core/kct_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kct_checker - port-level checks for the keyed cost table
// Watches the two channels of the top level and is bound onto it below.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kct_checker #(
    parameter int TABLE_DEPTH = 32
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_ok,
    input logic [kct_pkg::COST_W-1:0]  m_found_cost,
    input logic [kct_pkg::TOTAL_W-1:0] m_total_cents,
    input logic [kct_pkg::ECNT_W-1:0]  m_entry_count
);

    // a stalled result word holds
    `KCT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_ok) && $stable(m_found_cost) && $stable(m_total_cents))

    // one request walks the row at a time
    `KCT_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)

    // a total always succeeds, so a failed word carries no sum
    `KCT_ASSERT_NOW(a_fail_no_total, aclk, aresetn, m_valid && !m_ok, m_total_cents == '0 && m_found_cost == '0)

    // a found cost only comes with a successful retrieve
    `KCT_ASSERT_NOW(a_cost_only_get, aclk, aresetn, m_valid && m_found_cost != '0, m_ok && m_total_cents == '0)

    // the table never holds more than its depth
    `KCT_ASSERT_NOW(a_count_range, aclk, aresetn, m_valid && TABLE_DEPTH < 64, m_entry_count <= kct_pkg::ECNT_W'(TABLE_DEPTH))

endmodule

bind keyed_cost_table kct_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_kct_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_ok          (m_ok),
    .m_found_cost  (m_found_cost),
    .m_total_cents (m_total_cents),
    .m_entry_count (m_entry_count)
);
